// ----- hdl/nnip_pkg.sv -----
// ----------------------------------------------------------------------------
// nnip_pkg
// Shared constants, types and helpers for the nearest non-zero id pick block.
// ----------------------------------------------------------------------------
package nnip_pkg;

   // search window geometry
   localparam int SEARCH_RADIUS = 4;
   localparam int WINDOW_MAX    = 2 * SEARCH_RADIUS + 1;

   // field widths
   localparam int ID_W    = 32;
   localparam int COORD_W = 4;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_X      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_Y      = 2'd3;

   // register reset values
   localparam logic [COORD_W-1:0] RST_WINDOW_WIDTH  = 4'd9;
   localparam logic [COORD_W-1:0] RST_WINDOW_HEIGHT = 4'd9;
   localparam logic [COORD_W-1:0] RST_CURSOR_X      = 4'd4;
   localparam logic [COORD_W-1:0] RST_CURSOR_Y      = 4'd4;

   localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

   // window setup as seen by the search logic
   typedef struct packed {
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
   } window_cfg_type;

   // status and result from the search logic
   typedef struct packed {
      logic            last;
      logic [ID_W-1:0] picked_id;
      logic            found;
   } search_out_type;

   // window size forced into 1..WINDOW_MAX
   function automatic logic [COORD_W-1:0] clamp_size(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = COORD_W'(1);
      end else if (v > COORD_W'(WINDOW_MAX)) begin
         r = COORD_W'(WINDOW_MAX);
      end
      return r;
   endfunction

   // absolute difference of two coordinates
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = b - a;
      end
      return r;
   endfunction

endpackage

// ----- hdl/nnip_search.sv -----
// ----------------------------------------------------------------------------
// nnip_search
// Raster position counters and running nearest non-zero id for one window.
// ----------------------------------------------------------------------------
module nnip_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [nnip_pkg::ID_W-1:0]     id,
   input  nnip_pkg::window_cfg_type      cfg,
   output nnip_pkg::search_out_type      result
);

   logic [nnip_pkg::COORD_W-1:0] column_count_ff, column_count_in;
   logic [nnip_pkg::COORD_W-1:0] row_count_ff, row_count_in;
   logic [nnip_pkg::DIST_W-1:0]  best_distance_ff, best_distance_in;
   logic [nnip_pkg::ID_W-1:0]    best_id_ff, best_id_in;
   logic [nnip_pkg::ID_W-1:0]    exact_id_ff, exact_id_in;

   logic [nnip_pkg::COORD_W-1:0] dx, dy;
   logic [nnip_pkg::SQ_W-1:0]    sq_x, sq_y;
   logic [nnip_pkg::DIST_W-1:0]  sq_dist;
   logic [nnip_pkg::DIST_W-1:0]  best_dist_next;
   logic                         row_end;
   logic                         last;
   logic [nnip_pkg::ID_W-1:0]    exact_next, best_next, picked;

   // squared distance from the current texel to the cursor
   always_comb begin
      dx      = nnip_pkg::abs_diff(column_count_ff, cfg.cursor_x);
      dy      = nnip_pkg::abs_diff(row_count_ff, cfg.cursor_y);
      sq_x    = {{nnip_pkg::COORD_W{1'b0}}, dx} * {{nnip_pkg::COORD_W{1'b0}}, dx};
      sq_y    = {{nnip_pkg::COORD_W{1'b0}}, dy} * {{nnip_pkg::COORD_W{1'b0}}, dy};
      sq_dist = {1'b0, sq_x} + {1'b0, sq_y};
   end

   // end of row and end of window
   assign row_end = ({1'b0, column_count_ff} + (nnip_pkg::COORD_W + 1)'(1))
                    >= {1'b0, cfg.width};
   assign last    = row_end &&
                    (({1'b0, row_count_ff} + (nnip_pkg::COORD_W + 1)'(1))
                     >= {1'b0, cfg.height});

   // running minimum and cursor hit
   always_comb begin
      exact_next     = exact_id_ff;
      best_next      = best_id_ff;
      best_dist_next = best_distance_ff;
      if (column_count_ff == cfg.cursor_x && row_count_ff == cfg.cursor_y) begin
         exact_next = id;
      end
      if (id != '0 && sq_dist < best_distance_ff) begin
         best_dist_next = sq_dist;
         best_next      = id;
      end
      picked = (exact_next != '0) ? exact_next : best_next;
   end

   // next state: step the raster position or clear for the next window
   always_comb begin
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      best_distance_in = best_dist_next;
      best_id_in       = best_next;
      exact_id_in      = exact_next;
      if (last) begin
         column_count_in  = '0;
         row_count_in     = '0;
         best_distance_in = nnip_pkg::DIST_ALL_ONES;
         best_id_in       = '0;
         exact_id_in      = '0;
      end else if (row_end) begin
         column_count_in = '0;
         row_count_in    = row_count_ff + nnip_pkg::COORD_W'(1);
      end else begin
         column_count_in = column_count_ff + nnip_pkg::COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         best_distance_ff <= nnip_pkg::DIST_ALL_ONES;
         best_id_ff       <= '0;
         exact_id_ff      <= '0;
      end else if (advance) begin
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         best_distance_ff <= best_distance_in;
         best_id_ff       <= best_id_in;
         exact_id_ff      <= exact_id_in;
      end
   end

   assign result.last      = last;
   assign result.picked_id = picked;
   assign result.found     = (picked != '0);

endmodule

// ----- hdl/nearest_nonzero_id_pick_core.sv -----
// ----------------------------------------------------------------------------
// nearest_nonzero_id_pick_core
// Picks the id under the cursor, or else the nearest non-zero id, from a
// window of entity ids streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Program window size and cursor through the csr_ write port while idle.
//   Feed the window's ids, one item per texel in raster order, on the req_
//   valid/ready channel. After the last texel of the window one item leaves
//   on the rsp_ channel: the picked id, and found set when it is non-zero.
// Throughput and pipeline:
//   One texel item per cycle, unless a waiting result stalls the last
//   texel of a window. A texel sits in the input register while the distance
//   and running minimum update runs; the result register loads when the
//   last texel of the window advances out of the input register.
// Reset:
//   Registers return to a 9x9 window with the cursor at the center, and the
//   search restarts at the top left texel.
// Stall:
//   A waiting result holds the next window's last texel in the input register,
//   which then stalls req_ready; texels before it keep flowing.
// ----------------------------------------------------------------------------
module nearest_nonzero_id_pick_core (
   input  logic                             clock,
   input  logic                             reset,
   // texel items
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [nnip_pkg::ID_W-1:0]        req_entity_id,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nnip_pkg::ID_W-1:0]        rsp_picked_id,
   output logic                             rsp_found,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [nnip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnip_pkg::COORD_W-1:0]     csr_wdata
);

   logic [nnip_pkg::COORD_W-1:0] window_width_ff, window_height_ff;
   logic [nnip_pkg::COORD_W-1:0] cursor_x_ff, cursor_y_ff;

   logic                         in_valid_ff;
   logic [nnip_pkg::ID_W-1:0]    in_id_ff;
   logic                         rsp_valid_ff;
   logic [nnip_pkg::ID_W-1:0]    rsp_picked_id_ff;
   logic                         rsp_found_ff;

   nnip_pkg::window_cfg_type     cfg;
   nnip_pkg::search_out_type     search;
   logic                         advance;
   logic                         rsp_load;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff  <= nnip_pkg::RST_WINDOW_WIDTH;
         window_height_ff <= nnip_pkg::RST_WINDOW_HEIGHT;
         cursor_x_ff      <= nnip_pkg::RST_CURSOR_X;
         cursor_y_ff      <= nnip_pkg::RST_CURSOR_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            nnip_pkg::REG_WINDOW_WIDTH:  window_width_ff  <= csr_wdata;
            nnip_pkg::REG_WINDOW_HEIGHT: window_height_ff <= csr_wdata;
            nnip_pkg::REG_CURSOR_X:      cursor_x_ff      <= csr_wdata;
            nnip_pkg::REG_CURSOR_Y:      cursor_y_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.width    = nnip_pkg::clamp_size(window_width_ff);
   assign cfg.height   = nnip_pkg::clamp_size(window_height_ff);
   assign cfg.cursor_x = cursor_x_ff;
   assign cfg.cursor_y = cursor_y_ff;

   // stage handshake: only the last texel needs a free result register
   assign advance   = in_valid_ff && (!search.last || !rsp_valid_ff || rsp_ready);
   assign rsp_load  = advance && search.last;
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_id_ff <= req_entity_id;
      end
   end

   nnip_search u_search (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .id      (in_id_ff),
      .cfg     (cfg),
      .result  (search)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_picked_id_ff <= search.picked_id;
         rsp_found_ff     <= search.found;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_picked_id = rsp_picked_id_ff;
   assign rsp_found     = rsp_found_ff;

endmodule
